@@ rtl/sit_pkg.sv @@
// Shared widths, types and helpers of the segment intersection test.
package sit_pkg;

	// Coordinate width; every other width follows from it.
	localparam int CW = 32;
	// Width of a coordinate difference and of a point delta magnitude.
	localparam int DW = CW + 1;
	// Width of a product of two differences.
	localparam int PW = 2 * DW;
	// Width of a determinant or numerator before sign normalization.
	localparam int NW = PW + 1;
	// Width of a normalized (non-negative) determinant or numerator.
	localparam int MW = 2 * DW;
	// Width of the point numerator, delta magnitude times move numerator.
	localparam int NUMW = 3 * DW;
	// Width of the rounded quotient.
	localparam int QW = DW + 1;
	// Packed input and output data widths.
	localparam int IN_W = 8 * CW;
	localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
	// Latencies of the determinant front end and of the scaling divider.
	localparam int DET_LAT = 5;
	localparam int SCALE_LAT = DW + 3;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;

	// Range results that travel beside the divider.
	typedef struct packed {
		logic point_ok;
		logic hit;
	} sit_flags_t;

	// Values the point computation needs from the front end.
	typedef struct packed {
		coord_t xi;
		coord_t yi;
		diff_t  dxm;
		diff_t  dym;
	} sit_carry_t;

	// Sign-extend a coordinate to difference width.
	function automatic diff_t sx(input coord_t v);
		sx = {v[CW-1], v};
	endfunction

endpackage

@@ rtl/sit_det.sv @@
// Front end: differences, cross products, determinant, sign normalization and range tests.
module sit_det (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [sit_pkg::IN_W-1:0]    in_data,
	output logic                        out_valid,
	output sit_pkg::sit_carry_t         out_carry,
	output sit_pkg::sit_flags_t         out_flags,
	output logic [sit_pkg::MW-1:0]      out_det,
	output logic [sit_pkg::MW-1:0]      out_sn
);

	sit_pkg::coord_t c [8];

	logic [1:5] vld_s;

	sit_pkg::sit_carry_t carry_s1, carry_s2, carry_s3, carry_s4, carry_s5;
	sit_pkg::diff_t dxw_s1, dyw_s1, ex_s1, ey_s1;

	logic signed [sit_pkg::PW-1:0] p_det_a_s2, p_det_b_s2;
	logic signed [sit_pkg::PW-1:0] p_tn_a_s2, p_tn_b_s2;
	logic signed [sit_pkg::PW-1:0] p_sn_a_s2, p_sn_b_s2;

	logic signed [sit_pkg::NW-1:0] det_s3, tn_s3, sn_s3;
	logic signed [sit_pkg::NW-1:0] det_s4, tn_s4, sn_s4;
	logic zero_s4;

	sit_pkg::sit_flags_t flags_s5;
	logic [sit_pkg::MW-1:0] det_s5, sn_s5;

	logic s_ok, t_ok;

	// Unpack the eight coordinates, first field in the lowest bits.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			c[i] = in_data[i*sit_pkg::CW +: sit_pkg::CW];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {in_valid, vld_s[1:4]};
		end
	end

	// Stage 1: segment directions and the offset of the move start from the wall.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1.xi  <= c[0];
			carry_s1.yi  <= c[1];
			carry_s1.dxm <= sit_pkg::sx(c[2]) - sit_pkg::sx(c[0]);
			carry_s1.dym <= sit_pkg::sx(c[3]) - sit_pkg::sx(c[1]);
			dxw_s1       <= sit_pkg::sx(c[6]) - sit_pkg::sx(c[4]);
			dyw_s1       <= sit_pkg::sx(c[7]) - sit_pkg::sx(c[5]);
			ex_s1        <= sit_pkg::sx(c[0]) - sit_pkg::sx(c[4]);
			ey_s1        <= sit_pkg::sx(c[1]) - sit_pkg::sx(c[5]);
		end
	end

	// Stage 2: the six cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s2   <= carry_s1;
			p_det_a_s2 <= dyw_s1 * carry_s1.dxm;
			p_det_b_s2 <= dxw_s1 * carry_s1.dym;
			p_tn_a_s2  <= ey_s1 * carry_s1.dxm;
			p_tn_b_s2  <= ex_s1 * carry_s1.dym;
			p_sn_a_s2  <= ey_s1 * dxw_s1;
			p_sn_b_s2  <= ex_s1 * dyw_s1;
		end
	end

	// Stage 3: determinant and the two numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s3 <= carry_s2;
			det_s3   <= $signed({p_det_a_s2[sit_pkg::PW-1], p_det_a_s2})
			          - $signed({p_det_b_s2[sit_pkg::PW-1], p_det_b_s2});
			tn_s3    <= $signed({p_tn_a_s2[sit_pkg::PW-1], p_tn_a_s2})
			          - $signed({p_tn_b_s2[sit_pkg::PW-1], p_tn_b_s2});
			sn_s3    <= $signed({p_sn_a_s2[sit_pkg::PW-1], p_sn_a_s2})
			          - $signed({p_sn_b_s2[sit_pkg::PW-1], p_sn_b_s2});
		end
	end

	// Stage 4: make the determinant non-negative, flipping the numerators with it.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s4 <= carry_s3;
			zero_s4  <= (det_s3 == '0);
			if (det_s3[sit_pkg::NW-1]) begin
				det_s4 <= -det_s3;
				tn_s4  <= -tn_s3;
				sn_s4  <= -sn_s3;
			end else begin
				det_s4 <= det_s3;
				tn_s4  <= tn_s3;
				sn_s4  <= sn_s3;
			end
		end
	end

	// Both parameters lie in [0,1] when their numerators lie in [0,det].
	assign s_ok = !sn_s4[sit_pkg::NW-1] && (sn_s4 <= det_s4);
	assign t_ok = !tn_s4[sit_pkg::NW-1] && (tn_s4 <= det_s4);

	// Stage 5: range flags and the normalized magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			carry_s5          <= carry_s4;
			flags_s5.point_ok <= !zero_s4 && s_ok;
			flags_s5.hit      <= !zero_s4 && s_ok && t_ok;
			det_s5            <= det_s4[sit_pkg::MW-1:0];
			sn_s5             <= sn_s4[sit_pkg::MW-1:0];
		end
	end

	assign out_valid = vld_s[5];
	assign out_carry = carry_s5;
	assign out_flags = flags_s5;
	assign out_det   = det_s5;
	assign out_sn    = sn_s5;

endmodule

@@ rtl/sit_scale.sv @@
// Point delta scaling: exact product delta*sn, then a restoring divider by det, one bit a stage.
module sit_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  sit_pkg::coord_t             start,
	input  sit_pkg::diff_t              delta,
	input  logic [sit_pkg::MW-1:0]      det,
	input  logic [sit_pkg::MW-1:0]      sn,
	output logic                        out_valid,
	output sit_pkg::coord_t             out_start,
	output logic                        out_neg,
	output logic [sit_pkg::QW-1:0]      out_q
);

	localparam int DW = sit_pkg::DW;
	localparam int MW = sit_pkg::MW;

	logic [DW-1:0] mag;

	// Multiply stage.
	logic                  vld_m1;
	logic [MW-1:0]         p_lo_m1, p_hi_m1, det_m1;
	sit_pkg::coord_t       start_m1;
	logic                  neg_m1;

	// Divider stages; index 0 holds the assembled numerator.
	logic                  vld_d   [0:DW];
	logic [MW-1:0]         rem_d   [0:DW];
	logic [DW-1:0]         nl_d    [0:DW];
	logic [DW-1:0]         q_d     [0:DW];
	logic [MW-1:0]         det_d   [0:DW];
	sit_pkg::coord_t       start_d [0:DW];
	logic                  neg_d   [0:DW];

	logic [sit_pkg::NUMW-1:0] num;

	// Rounding stage.
	logic                  vld_r;
	sit_pkg::coord_t       start_r;
	logic                  neg_r;
	logic [sit_pkg::QW-1:0] q_r;

	assign mag = delta[DW-1] ? (~delta + 1'b1) : delta;

	// Stage M1: two partial products cover the full move numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			p_lo_m1  <= mag * sn[DW-1:0];
			p_hi_m1  <= mag * sn[MW-1:DW];
			det_m1   <= det;
			start_m1 <= start;
			neg_m1   <= delta[DW-1];
		end
	end

	assign num = sit_pkg::NUMW'(p_lo_m1) + {p_hi_m1, {DW{1'b0}}};

	// Stage D0: the high part of the numerator is already below det.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0]   <= num[sit_pkg::NUMW-1:DW];
			nl_d[0]    <= num[DW-1:0];
			q_d[0]     <= '0;
			det_d[0]   <= det_m1;
			start_d[0] <= start_m1;
			neg_d[0]   <= neg_m1;
		end
	end

	// Valid bits of the multiply and first divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1   <= 1'b0;
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_m1   <= in_valid;
			vld_d[0] <= vld_m1;
		end
	end

	// One quotient bit per stage: shift in a numerator bit, subtract det when it fits.
	for (genvar k = 1; k <= DW; k++) begin : g_step
		logic [MW:0] trial;
		logic        fits;

		always_comb begin
			trial = {rem_d[k-1], nl_d[k-1][DW-1]};
			fits  = (trial >= {1'b0, det_d[k-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[k] <= 1'b0;
			end else if (en) begin
				vld_d[k] <= vld_d[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[k]   <= fits ? MW'(trial - {1'b0, det_d[k-1]}) : MW'(trial);
				nl_d[k]    <= {nl_d[k-1][DW-2:0], 1'b0};
				q_d[k]     <= {q_d[k-1][DW-2:0], fits};
				det_d[k]   <= det_d[k-1];
				start_d[k] <= start_d[k-1];
				neg_d[k]   <= neg_d[k-1];
			end
		end
	end

	// Rounding stage: round to nearest, ties away from zero on the magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r <= 1'b0;
		end else if (en) begin
			vld_r <= vld_d[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			start_r <= start_d[DW];
			neg_r   <= neg_d[DW];
			q_r     <= sit_pkg::QW'(q_d[DW])
			         + sit_pkg::QW'({rem_d[DW], 1'b0} >= {1'b0, det_d[DW]});
		end
	end

	assign out_valid = vld_r;
	assign out_start = start_r;
	assign out_neg   = neg_r;
	assign out_q     = q_r;

endmodule

@@ rtl/segment_intersection_test.sv @@
// Top level of the segment intersection test: front end, two scaling dividers, output stage.
//
// Tests a move segment against a wall segment in signed fixed point and returns the hit
// flag, the point-valid flag and the intersection point, one result per input transaction.
// The block is a fully pipelined datapath with no state between items: it takes a new
// transaction every cycle while the result side accepts, and passes each one through the
// front end, the two scaling dividers and the output register. Most of the pipeline is the
// restoring divider, which resolves one quotient bit per stage. When the result side stalls,
// the whole pipeline holds and input tready drops until the waiting result is taken.
module segment_intersection_test (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// move_start_x, move_start_y, move_end_x, move_end_y,
	// wall_left_x, wall_left_y, wall_right_x, wall_right_y
	input  logic [sit_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// point_x, point_y
	output logic [sit_pkg::OUT_W-1:0]      m_tdata,
	// hit, point_valid
	output logic [1:0]                     m_tuser
);

	localparam int CW = sit_pkg::CW;
	localparam int SW = CW + 3;

	logic                   en;
	logic                   det_valid;
	sit_pkg::sit_carry_t    det_carry;
	sit_pkg::sit_flags_t    det_flags;
	logic [sit_pkg::MW-1:0] det_mag, sn_mag;

	logic                   x_valid, y_valid;
	sit_pkg::coord_t        x_start, y_start;
	logic                   x_neg, y_neg;
	logic [sit_pkg::QW-1:0] x_q, y_q;

	sit_pkg::sit_flags_t    flags_d [0:sit_pkg::SCALE_LAT-1];

	sit_pkg::coord_t        px, py;

	logic                   valid_q;
	logic [sit_pkg::OUT_W-1:0] data_q;
	logic [1:0]             user_q;

	// The pipeline advances whenever the output register is free or being drained.
	assign en       = !valid_q || m_tready;
	assign s_tready = en;

	sit_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.out_valid (det_valid),
		.out_carry (det_carry),
		.out_flags (det_flags),
		.out_det   (det_mag),
		.out_sn    (sn_mag)
	);

	sit_scale u_scale_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (det_valid),
		.start     (det_carry.xi),
		.delta     (det_carry.dxm),
		.det       (det_mag),
		.sn        (sn_mag),
		.out_valid (x_valid),
		.out_start (x_start),
		.out_neg   (x_neg),
		.out_q     (x_q)
	);

	sit_scale u_scale_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (det_valid),
		.start     (det_carry.yi),
		.delta     (det_carry.dym),
		.det       (det_mag),
		.sn        (sn_mag),
		.out_valid (y_valid),
		.out_start (y_start),
		.out_neg   (y_neg),
		.out_q     (y_q)
	);

	// Range flags ride alongside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			flags_d[0] <= det_flags;
			for (int k = 1; k < sit_pkg::SCALE_LAT; k++) begin
				flags_d[k] <= flags_d[k-1];
			end
		end
	end

	// Add the signed scaled delta to the start and saturate to the coordinate range.
	function automatic sit_pkg::coord_t place(input sit_pkg::coord_t st, input logic neg,
			input logic [sit_pkg::QW-1:0] q);
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] qx;
		qx  = $signed(SW'(q));
		sum = $signed({{3{st[CW-1]}}, st}) + (neg ? -qx : qx);
		if (sum > $signed(SW'({1'b0, {(CW-1){1'b1}}}))) begin
			place = {1'b0, {(CW-1){1'b1}}};
		end else if (sum < $signed({{4{1'b1}}, {(CW-1){1'b0}}})) begin
			place = {1'b1, {(CW-1){1'b0}}};
		end else begin
			place = sum[CW-1:0];
		end
	endfunction

	always_comb begin
		px = '0;
		py = '0;
		if (flags_d[sit_pkg::SCALE_LAT-1].point_ok) begin
			px = place(x_start, x_neg, x_q);
			py = place(y_start, y_neg, y_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= x_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= sit_pkg::OUT_W'({py, px});
			user_q <= {flags_d[sit_pkg::SCALE_LAT-1].point_ok,
			           flags_d[sit_pkg::SCALE_LAT-1].hit};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

`ifndef ASSERT_OFF
	// Both dividers see the same valid stream.
	a_scale_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		x_valid == y_valid) else $error("scaling dividers out of step");

	// A hit needs the point to be valid.
	a_hit_has_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser[0] || m_tuser[1])) else $error("hit without a point");

	// Without a valid point the coordinates are zero.
	a_no_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[1]) |-> (m_tdata == '0)) else $error("point not cleared");

	// A held result keeps the pipeline frozen.
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(x_q) && $stable(x_valid))
		else $error("pipeline moved during a stall");
`endif

endmodule
